@@ rtl/aap_pkg.sv @@
package aap_pkg;

   localparam int FIELD_DIGITS_DEF = 4;
   localparam int QUEUE_DEPTH      = 2;

   localparam int CHAR_W  = 8;
   localparam int VALUE_W = 14;
   localparam int DIGIT_W = 4;

   localparam logic [CHAR_W-1:0]  HEADER_RESET = 8'h41;
   localparam logic [CHAR_W-1:0]  CHAR_ZERO    = 8'h30;   // '0'
   localparam logic [CHAR_W-1:0]  CHAR_ONE     = 8'h31;   // '1'
   localparam logic [CHAR_W-1:0]  CHAR_NINE    = 8'h39;   // '9'
   localparam logic [VALUE_W-1:0] VALUE_MAX    = 14'h3FFF;

   // what the back end does with one byte
   typedef enum logic [2:0] {
      OP_NONE,
      OP_HEADER,
      OP_YAW,
      OP_PITCH,
      OP_DIST,
      OP_TARGET,
      OP_FLAG
   } op_type;

   typedef enum logic [2:0] {
      ERR_NONE   = 3'd0,
      ERR_LENGTH = 3'd1,
      ERR_HEADER = 3'd2,
      ERR_DIGIT  = 3'd3,
      ERR_FLAG   = 3'd4
   } err_type;

   // one classified byte, front to back
   typedef struct packed {
      op_type             op;
      logic               bad;     // byte fails the check for its slot
      logic [DIGIT_W-1:0] digit;
      logic               fire;
      logic               last;
      logic               len_ok;  // only meaningful with last
   } entry_type;

   // acc*10 + d, clamped to the field maximum
   function automatic logic [VALUE_W-1:0] shift_digit(input logic [VALUE_W-1:0] acc,
                                                       input logic [DIGIT_W-1:0] d);
      logic [VALUE_W+3:0] nxt;
      nxt = (VALUE_W+4)'(acc) * (VALUE_W+4)'(10) + (VALUE_W+4)'(d);
      if (nxt > (VALUE_W+4)'(VALUE_MAX))
         shift_digit = VALUE_MAX;
      else
         shift_digit = nxt[VALUE_W-1:0];
   endfunction

endpackage

@@ rtl/aap_front.sv @@
module aap_front
   import aap_pkg::*;
#(
   parameter int FIELD_DIGITS = FIELD_DIGITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [CHAR_W-1:0] csr_wr_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CHAR_W-1:0] req_char_in,
   input  logic              req_end_of_packet,
   output logic              push_valid,
   input  logic              push_ready,
   output entry_type         push_entry
);

   localparam int PACKET_LEN = 3 * FIELD_DIGITS + 4;
   localparam int POS_CAP    = PACKET_LEN + 1;
   localparam int POS_W      = $clog2(POS_CAP + 1);
   localparam int YAW_END    = 2 + FIELD_DIGITS;
   localparam int PITCH_END  = 2 + 2 * FIELD_DIGITS;
   localparam int DIST_END   = 2 + 3 * FIELD_DIGITS;

   logic [CHAR_W-1:0] header_ff;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              term_ff, term_in;
   logic              accept;
   logic              counted;
   logic              is_digit;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;

   always_comb begin
      counted  = !term_ff && (req_char_in != '0);
      is_digit = req_char_in inside {[CHAR_ZERO:CHAR_NINE]};
      pos_in   = (counted && pos_ff != POS_W'(POS_CAP)) ? pos_ff + POS_W'(1) : pos_ff;
      term_in  = term_ff || (req_char_in == '0);

      push_entry.op     = OP_NONE;
      push_entry.bad    = 1'b0;
      push_entry.digit  = DIGIT_W'(req_char_in - CHAR_ZERO);
      push_entry.fire   = req_char_in[0];
      push_entry.last   = req_end_of_packet;
      push_entry.len_ok = (pos_in == POS_W'(PACKET_LEN));

      if (counted && pos_ff < POS_W'(PACKET_LEN)) begin
         if (pos_ff == '0) begin
            push_entry.op  = OP_HEADER;
            push_entry.bad = (req_char_in != header_ff);
         end else if (pos_ff >= POS_W'(2) && pos_ff <= POS_W'(PACKET_LEN - 2)) begin
            push_entry.bad = !is_digit;
            if (pos_ff < POS_W'(YAW_END))
               push_entry.op = OP_YAW;
            else if (pos_ff < POS_W'(PITCH_END))
               push_entry.op = OP_PITCH;
            else if (pos_ff < POS_W'(DIST_END))
               push_entry.op = OP_DIST;
            else
               push_entry.op = OP_TARGET;
         end else if (pos_ff == POS_W'(PACKET_LEN - 1)) begin
            push_entry.op  = OP_FLAG;
            push_entry.bad = (req_char_in != CHAR_ZERO) && (req_char_in != CHAR_ONE);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= HEADER_RESET;
         pos_ff    <= '0;
         term_ff   <= 1'b0;
      end else begin
         if (csr_wr_en)
            header_ff <= csr_wr_data;
         if (accept) begin
            if (req_end_of_packet) begin
               pos_ff  <= '0;
               term_ff <= 1'b0;
            end else begin
               pos_ff  <= pos_in;
               term_ff <= term_in;
            end
         end
      end
   end

endmodule

@@ rtl/aap_queue.sv @@
module aap_queue
   import aap_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  entry_type push_entry,
   output logic      pop_valid,
   input  logic      pop_ready,
   output entry_type pop_entry
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (push)
         slot_ff[wr_ptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push)
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         if (pop)
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         if (push && !pop)
            count_ff <= count_ff + CNT_W'(1);
         else if (pop && !push)
            count_ff <= count_ff - CNT_W'(1);
      end
   end

endmodule

@@ rtl/aap_back.sv @@
module aap_back
   import aap_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  entry_type          pop_entry,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_packet_ok,
   output logic [2:0]         rsp_error_kind,
   output logic [VALUE_W-1:0] rsp_yaw_value,
   output logic [VALUE_W-1:0] rsp_pitch_value,
   output logic [VALUE_W-1:0] rsp_distance_value,
   output logic [DIGIT_W-1:0] rsp_target_number,
   output logic               rsp_fire_command
);

   err_type            err_ff, err_in, final_err;
   logic [VALUE_W-1:0] yaw_ff, yaw_in;
   logic [VALUE_W-1:0] pitch_ff, pitch_in;
   logic [VALUE_W-1:0] dist_ff, dist_in;
   logic [DIGIT_W-1:0] target_ff, target_in;
   logic               fire_ff, fire_in;
   logic               rsp_valid_ff;
   logic               pop;
   logic               out_free;

   // payload register
   logic               ok_ff;
   err_type            kind_ff;
   logic [VALUE_W-1:0] yaw_out_ff, pitch_out_ff, dist_out_ff;
   logic [DIGIT_W-1:0] target_out_ff;
   logic               fire_out_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   // only the end-marked beat needs room in the output register
   assign pop_ready = !pop_entry.last || out_free;
   assign pop       = pop_valid && pop_ready;

   always_comb begin
      err_in    = err_ff;
      yaw_in    = yaw_ff;
      pitch_in  = pitch_ff;
      dist_in   = dist_ff;
      target_in = target_ff;
      fire_in   = fire_ff;
      if (err_ff == ERR_NONE) begin
         if (pop_entry.bad) begin
            case (pop_entry.op)
               OP_HEADER: err_in = ERR_HEADER;
               OP_FLAG:   err_in = ERR_FLAG;
               OP_YAW, OP_PITCH, OP_DIST, OP_TARGET: err_in = ERR_DIGIT;
               default:   err_in = err_ff;
            endcase
         end else begin
            case (pop_entry.op)
               OP_YAW:    yaw_in    = shift_digit(yaw_ff, pop_entry.digit);
               OP_PITCH:  pitch_in  = shift_digit(pitch_ff, pop_entry.digit);
               OP_DIST:   dist_in   = shift_digit(dist_ff, pop_entry.digit);
               OP_TARGET: target_in = pop_entry.digit;
               OP_FLAG:   fire_in   = pop_entry.fire;
               default:   ;
            endcase
         end
      end
      final_err = pop_entry.len_ok ? err_in : ERR_LENGTH;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff       <= ERR_NONE;
         yaw_ff       <= '0;
         pitch_ff     <= '0;
         dist_ff      <= '0;
         target_ff    <= '0;
         fire_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            if (pop_entry.last) begin
               err_ff    <= ERR_NONE;
               yaw_ff    <= '0;
               pitch_ff  <= '0;
               dist_ff   <= '0;
               target_ff <= '0;
               fire_ff   <= 1'b0;
            end else begin
               err_ff    <= err_in;
               yaw_ff    <= yaw_in;
               pitch_ff  <= pitch_in;
               dist_ff   <= dist_in;
               target_ff <= target_in;
               fire_ff   <= fire_in;
            end
         end
         if (pop && pop_entry.last)
            rsp_valid_ff <= 1'b1;
         else if (rsp_ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && pop_entry.last) begin
         ok_ff         <= (final_err == ERR_NONE);
         kind_ff       <= final_err;
         yaw_out_ff    <= (final_err == ERR_NONE) ? yaw_in    : '0;
         pitch_out_ff  <= (final_err == ERR_NONE) ? pitch_in  : '0;
         dist_out_ff   <= (final_err == ERR_NONE) ? dist_in   : '0;
         target_out_ff <= (final_err == ERR_NONE) ? target_in : '0;
         fire_out_ff   <= (final_err == ERR_NONE) ? fire_in   : 1'b0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_packet_ok      = ok_ff;
   assign rsp_error_kind     = kind_ff;
   assign rsp_yaw_value      = yaw_out_ff;
   assign rsp_pitch_value    = pitch_out_ff;
   assign rsp_distance_value = dist_out_ff;
   assign rsp_target_number  = target_out_ff;
   assign rsp_fire_command   = fire_out_ff;

endmodule

@@ rtl/ascii_aim_packet_parser.sv @@
// Channel   Dir  Handshake                 Beat payload
// req_      in   req_valid / req_ready     char_in, end_of_packet (one packet byte)
// rsp_      out  rsp_valid / rsp_ready     packet_ok, error_kind, yaw/pitch/distance,
//                                          target_number, fire_command (one per packet)
// csr_      in   csr_wr_en, no wait        wr_data = required header byte
//
// One byte beat per cycle sustained while rsp_ is not stalled. The front end classifies a byte by its
// position in the packet; the back end runs the times-ten accumulate.
// A packet's result shows on rsp_ once its end-marked byte beat has passed
// through the queue: the edge that takes the beat writes the queue, a later
// edge pops it and loads the output register.
// Reset (synchronous) clears the position counter, queue, accumulators and
// output valid, and loads the header register with 'A'.
// A two-entry queue splits front and back; a stalled rsp_ holds only an end-marked
// beat at the queue head, bytes ahead of it drain into the accumulators, later bytes wait.
module ascii_aim_packet_parser
   import aap_pkg::*;
#(
   parameter int FIELD_DIGITS = FIELD_DIGITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // config
   input  logic               csr_wr_en,
   input  logic [CHAR_W-1:0]  csr_wr_data,
   // byte input
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [CHAR_W-1:0]  req_char_in,
   input  logic               req_end_of_packet,
   // packet result
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_packet_ok,
   output logic [2:0]         rsp_error_kind,
   output logic [VALUE_W-1:0] rsp_yaw_value,
   output logic [VALUE_W-1:0] rsp_pitch_value,
   output logic [VALUE_W-1:0] rsp_distance_value,
   output logic [DIGIT_W-1:0] rsp_target_number,
   output logic               rsp_fire_command
);

   // front -> queue
   logic      push_valid, push_ready;
   entry_type push_entry;
   // queue -> back
   logic      pop_valid, pop_ready;
   entry_type pop_entry;

   // position tracking, zero-byte termination, per-slot checks
   aap_front #(
      .FIELD_DIGITS(FIELD_DIGITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_in       (req_char_in),
      .req_end_of_packet (req_end_of_packet),
      .push_valid        (push_valid),
      .push_ready        (push_ready),
      .push_entry        (push_entry)
   );

   aap_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // sticky error, field accumulators, result register
   aap_back u_back (
      .clock              (clock),
      .reset              (reset),
      .pop_valid          (pop_valid),
      .pop_ready          (pop_ready),
      .pop_entry          (pop_entry),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_packet_ok      (rsp_packet_ok),
      .rsp_error_kind     (rsp_error_kind),
      .rsp_yaw_value      (rsp_yaw_value),
      .rsp_pitch_value    (rsp_pitch_value),
      .rsp_distance_value (rsp_distance_value),
      .rsp_target_number  (rsp_target_number),
      .rsp_fire_command   (rsp_fire_command)
   );

endmodule

@@ bench/aim_packet_checker.sv @@
module aim_packet_checker
   import aap_pkg::*;
#(
   parameter int FIELD_DIGITS = FIELD_DIGITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [CHAR_W-1:0]  csr_wr_data,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [CHAR_W-1:0]  req_char_in,
   input  logic               req_end_of_packet,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic               rsp_packet_ok,
   input  logic [2:0]         rsp_error_kind,
   input  logic [VALUE_W-1:0] rsp_yaw_value,
   input  logic [VALUE_W-1:0] rsp_pitch_value,
   input  logic [VALUE_W-1:0] rsp_distance_value,
   input  logic [DIGIT_W-1:0] rsp_target_number,
   input  logic               rsp_fire_command,
   output int                 mismatches,
   output int                 pending
);

   localparam int PKT_LEN = 3 * FIELD_DIGITS + 4;

   typedef struct packed {
      logic               ok;
      err_type            kind;
      logic [VALUE_W-1:0] yaw;
      logic [VALUE_W-1:0] pitch;
      logic [VALUE_W-1:0] distance;
      logic [DIGIT_W-1:0] target;
      logic               fire;
   } aim_result_type;

   aim_result_type awaited_results[$];

   logic [CHAR_W-1:0]  header_reg;
   int                 byte_count;
   err_type            first_err;
   logic [VALUE_W-1:0] yaw_acc;
   logic [VALUE_W-1:0] pitch_acc;
   logic [VALUE_W-1:0] dist_acc;
   logic [DIGIT_W-1:0] target_acc;
   logic               fire_acc;
   logic               zero_seen;
   int                 fail_total;

   // decimal shift-in, clamped at the field maximum
   function automatic logic [VALUE_W-1:0] times_ten_plus(input logic [VALUE_W-1:0] acc,
                                                         input logic [CHAR_W-1:0]  c);
      int sum;
      sum = int'(acc) * 10 + int'(c - CHAR_ZERO);
      if (sum > int'(VALUE_MAX))
         return VALUE_MAX;
      return sum[VALUE_W-1:0];
   endfunction

   task automatic clear_packet();
      byte_count = 0;
      first_err  = ERR_NONE;
      yaw_acc    = '0;
      pitch_acc  = '0;
      dist_acc   = '0;
      target_acc = '0;
      fire_acc   = 1'b0;
      zero_seen  = 1'b0;
   endtask

   // slot check for the byte at byte_count; first content error sticks
   task automatic classify(input logic [CHAR_W-1:0] c);
      logic is_digit;
      is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      if (first_err != ERR_NONE)
         return;
      if (byte_count == 0) begin
         if (c != header_reg)
            first_err = ERR_HEADER;
      end else if (byte_count >= 2 && byte_count <= PKT_LEN - 2) begin
         if (!is_digit)
            first_err = ERR_DIGIT;
         else if (byte_count < 2 + FIELD_DIGITS)
            yaw_acc = times_ten_plus(yaw_acc, c);
         else if (byte_count < 2 + 2 * FIELD_DIGITS)
            pitch_acc = times_ten_plus(pitch_acc, c);
         else if (byte_count < 2 + 3 * FIELD_DIGITS)
            dist_acc = times_ten_plus(dist_acc, c);
         else
            target_acc = c[DIGIT_W-1:0];
      end else if (byte_count == PKT_LEN - 1) begin
         if (c == CHAR_ZERO || c == CHAR_ONE)
            fire_acc = c[0];
         else
            first_err = ERR_FLAG;
      end
   endtask

   always @(posedge clock) begin : watch
      aim_result_type exp_r;
      err_type        verdict;
      if (reset) begin
         header_reg = HEADER_RESET;
         clear_packet();
         awaited_results.delete();
         fail_total = 0;
      end else begin
         if (csr_wr_en)
            header_reg = csr_wr_data;

         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               fail_total++;
               if (fail_total <= 10)
                  $display("%0t: result beat with nothing awaited: ok=%0d err=%0d", $time,
                           rsp_packet_ok, rsp_error_kind);
            end else begin
               exp_r = awaited_results.pop_front();
               if (rsp_packet_ok !== exp_r.ok || rsp_error_kind !== exp_r.kind ||
                   rsp_yaw_value !== exp_r.yaw || rsp_pitch_value !== exp_r.pitch ||
                   rsp_distance_value !== exp_r.distance ||
                   rsp_target_number !== exp_r.target ||
                   rsp_fire_command !== exp_r.fire) begin
                  fail_total++;
                  if (fail_total <= 10) begin
                     $display("%0t: result mismatch", $time);
                     $display("  expected ok=%0d err=%0d yaw=%0d pitch=%0d dist=%0d tgt=%0d fire=%0d",
                              exp_r.ok, exp_r.kind, exp_r.yaw, exp_r.pitch, exp_r.distance,
                              exp_r.target, exp_r.fire);
                     $display("  actual   ok=%0d err=%0d yaw=%0d pitch=%0d dist=%0d tgt=%0d fire=%0d",
                              rsp_packet_ok, rsp_error_kind, rsp_yaw_value, rsp_pitch_value,
                              rsp_distance_value, rsp_target_number, rsp_fire_command);
                  end
               end
            end
         end

         if (req_valid && req_ready) begin
            // zero byte ends the effective length; rest of packet ignored
            if (!zero_seen) begin
               if (req_char_in == '0)
                  zero_seen = 1'b1;
               else begin
                  if (byte_count < PKT_LEN)
                     classify(req_char_in);
                  if (byte_count <= PKT_LEN)
                     byte_count++;
               end
            end
            if (req_end_of_packet) begin
               verdict    = (byte_count != PKT_LEN) ? ERR_LENGTH : first_err;
               exp_r      = '0;
               exp_r.kind = verdict;
               exp_r.ok   = (verdict == ERR_NONE);
               if (verdict == ERR_NONE) begin
                  exp_r.yaw      = yaw_acc;
                  exp_r.pitch    = pitch_acc;
                  exp_r.distance = dist_acc;
                  exp_r.target   = target_acc;
                  exp_r.fire     = fire_acc;
               end
               awaited_results.push_back(exp_r);
               clear_packet();
            end
         end
      end
      mismatches <= fail_total;
      pending    <= awaited_results.size();
   end

endmodule

@@ bench/testbench.sv @@
module testbench;
   import aap_pkg::*;

   localparam int PKT_LEN     = 3 * FIELD_DIGITS_DEF + 4;
   localparam int PHASE_BEATS = 350;   // byte beats per header setting
   localparam int STALL_LIMIT = 500;   // cycles with no beat on either channel

   logic               clock             = 1'b0;
   logic               reset             = 1'b1;
   logic               csr_wr_en         = 1'b0;
   logic [CHAR_W-1:0]  csr_wr_data       = '0;
   logic               req_valid         = 1'b0;
   logic               req_ready;
   logic [CHAR_W-1:0]  req_char_in       = '0;
   logic               req_end_of_packet = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready         = 1'b0;
   logic               rsp_packet_ok;
   logic [2:0]         rsp_error_kind;
   logic [VALUE_W-1:0] rsp_yaw_value;
   logic [VALUE_W-1:0] rsp_pitch_value;
   logic [VALUE_W-1:0] rsp_distance_value;
   logic [DIGIT_W-1:0] rsp_target_number;
   logic               rsp_fire_command;

   int mismatches;
   int pending;

   // steady = no idling on either side for the current packet
   logic steady       = 1'b0;
   logic rsp_taken    = 1'b0;
   int   rsp_hold     = 0;
   int   quiet_cycles = 0;
   int   beats_sent   = 0;

   logic [CHAR_W-1:0] pkt[$];   // byte beats of the packet being built

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   ascii_aim_packet_parser i_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_char_in        (req_char_in),
      .req_end_of_packet  (req_end_of_packet),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_packet_ok      (rsp_packet_ok),
      .rsp_error_kind     (rsp_error_kind),
      .rsp_yaw_value      (rsp_yaw_value),
      .rsp_pitch_value    (rsp_pitch_value),
      .rsp_distance_value (rsp_distance_value),
      .rsp_target_number  (rsp_target_number),
      .rsp_fire_command   (rsp_fire_command)
   );

   aim_packet_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_char_in        (req_char_in),
      .req_end_of_packet  (req_end_of_packet),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_packet_ok      (rsp_packet_ok),
      .rsp_error_kind     (rsp_error_kind),
      .rsp_yaw_value      (rsp_yaw_value),
      .rsp_pitch_value    (rsp_pitch_value),
      .rsp_distance_value (rsp_distance_value),
      .rsp_target_number  (rsp_target_number),
      .rsp_fire_command   (rsp_fire_command),
      .mismatches         (mismatches),
      .pending            (pending)
   );

   // Result side: after each accepted result beat, hold ready low for a randomly
   // drawn hold, then raise it and leave it up until the next beat goes through.
   // rsp_taken is captured at the rising edge, acted on at the falling edge.
   always @(posedge clock) begin
      rsp_taken <= !reset && rsp_valid && rsp_ready;
   end

   always @(negedge clock) begin : rsp_side
      int hold;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= $urandom_range(0, 4);
      end else if (rsp_taken) begin
         hold = steady ? 0 : $urandom_range(0, 4);
         if (hold == 0)
            rsp_ready <= 1'b1;
         else begin
            rsp_ready <= 1'b0;
            rsp_hold  <= hold - 1;
         end
      end else if (!rsp_ready) begin
         if (rsp_hold == 0)
            rsp_ready <= 1'b1;
         else
            rsp_hold <= rsp_hold - 1;
      end
   end

   // Watchdog: a long run of cycles with no beat on either channel means the
   // block has hung (or dropped a result the sender is waiting on).
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= STALL_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   // One byte beat. Payload changes at the falling edge; valid stays up
   // straight into the next beat when no gap is drawn, so it is never
   // lowered and raised in the same step.
   task automatic send_beat(input logic [CHAR_W-1:0] c, input logic last);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_char_in       <= c;
      req_end_of_packet <= last;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic send_packet();
      foreach (pkt[i])
         send_beat(pkt[i], i == pkt.size() - 1);
   endtask

   // Stop sending and wait for every awaited result, plus a few cycles so
   // the back end is surely empty.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // header register may only change while the block is idle
   task automatic write_header(input logic [CHAR_W-1:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [CHAR_W-1:0] rand_digit();
      return CHAR_ZERO + CHAR_W'($urandom_range(0, 9));
   endfunction

   // nonzero, so it is a content error and not a terminator
   function automatic logic [CHAR_W-1:0] rand_non_digit();
      logic [CHAR_W-1:0] c;
      do
         c = CHAR_W'($urandom_range(1, 255));
      while (c >= CHAR_ZERO && c <= CHAR_NINE);
      return c;
   endfunction

   function automatic logic [CHAR_W-1:0] rand_bad_flag();
      logic [CHAR_W-1:0] c;
      do
         c = CHAR_W'($urandom_range(1, 255));
      while (c == CHAR_ZERO || c == CHAR_ONE);
      return c;
   endfunction

   // Well-formed packet: header, free byte, three decimal fields (sometimes
   // all zeros or all nines to hit the field extremes), target, fire flag.
   task automatic build_good(input logic [CHAR_W-1:0] hdr);
      int mode;
      pkt.delete();
      pkt.push_back(hdr);
      pkt.push_back(CHAR_W'($urandom_range(1, 255)));
      repeat (3) begin
         mode = $urandom_range(0, 7);
         repeat (FIELD_DIGITS_DEF)
            pkt.push_back(mode == 0 ? CHAR_ZERO : mode == 1 ? CHAR_NINE : rand_digit());
      end
      pkt.push_back(rand_digit());
      pkt.push_back($urandom_range(0, 1) ? CHAR_ONE : CHAR_ZERO);
   endtask

   // Half good packets; the rest are good packets with one defect (or more,
   // to check which error wins), plus a little pure noise.
   task automatic make_packet(input logic [CHAR_W-1:0] hdr);
      int                roll;
      int                keep;
      logic [CHAR_W-1:0] h;
      roll = $urandom_range(0, 99);
      build_good(hdr);
      if (roll < 50) begin
         // left as is
      end else if (roll < 58) begin
         // wrong header, sometimes with a later bad digit behind it
         do
            h = CHAR_W'($urandom_range(1, 255));
         while (h == hdr);
         pkt[0] = h;
         if ($urandom_range(0, 1))
            pkt[$urandom_range(2, PKT_LEN - 2)] = rand_non_digit();
      end else if (roll < 68) begin
         // non-digit in a field or the target; first error must stick
         pkt[$urandom_range(2, PKT_LEN - 2)] = rand_non_digit();
         if ($urandom_range(0, 1))
            pkt[PKT_LEN - 1] = rand_bad_flag();
         if ($urandom_range(0, 3) == 0)
            pkt[$urandom_range(2, PKT_LEN - 2)] = rand_non_digit();
      end else if (roll < 76) begin
         pkt[PKT_LEN - 1] = rand_bad_flag();
      end else if (roll < 83) begin
         // short packet
         keep = $urandom_range(1, PKT_LEN - 1);
         while (pkt.size() > keep)
            void'(pkt.pop_back());
      end else if (roll < 90) begin
         // long packet: extra bytes past the flag are never checked
         repeat ($urandom_range(1, 4))
            pkt.push_back(CHAR_W'($urandom_range(0, 255)));
      end else if (roll < 97) begin
         // zero byte cuts the packet; bytes after it are ignored
         pkt[$urandom_range(0, PKT_LEN - 1)] = '0;
         if ($urandom_range(0, 1))
            pkt.push_back(CHAR_W'($urandom_range(0, 255)));
      end else begin
         pkt.delete();
         repeat ($urandom_range(1, 20))
            pkt.push_back(CHAR_W'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      logic [CHAR_W-1:0] hdr;
      int                phase;

      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: maximal packet (all nines, free byte all ones, fire set),
      // a one-byte packet, and a lone zero byte carrying the end marker.
      hdr = HEADER_RESET;
      pkt.delete();
      pkt.push_back(HEADER_RESET);
      pkt.push_back(8'hFF);
      repeat (3 * FIELD_DIGITS_DEF + 1)
         pkt.push_back(CHAR_NINE);
      pkt.push_back(CHAR_ONE);
      send_packet();
      pkt.delete();
      pkt.push_back(HEADER_RESET);
      send_packet();
      pkt.delete();
      pkt.push_back('0);
      send_packet();

      // Random phases, one per header setting. Phase 0 runs on the reset
      // value; all-ones and zero (never matches) are the extremes. Each
      // header write first drains the block completely.
      for (phase = 0; phase < 5; phase++) begin
         if (phase > 0) begin
            case (phase)
               1: hdr = 8'hFF;
               2: hdr = 8'h00;
               3: hdr = CHAR_W'($urandom_range(1, 254));
               default: hdr = 8'h01;
            endcase
            write_header(hdr);
         end
         while (beats_sent < (phase + 1) * PHASE_BEATS) begin
            steady = ($urandom_range(0, 5) == 0);
            make_packet(hdr);
            send_packet();
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && pending == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/aap_pkg.sv
rtl/aap_front.sv
rtl/aap_queue.sv
rtl/aap_back.sv
rtl/ascii_aim_packet_parser.sv
bench/aim_packet_checker.sv
bench/testbench.sv
